// File: hdl/bppe_pkg.sv
// Shared types, codes and constants of the blended piecewise polynomial evaluator.
`timescale 1ns / 1ps
package bppe_pkg;

    localparam int DEF_MAX_SPANS  = 64;
    localparam int DEF_MAX_DEGREE = 19;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 6;
    localparam int TIME_W  = 48;
    localparam int DEG_W   = 5;
    localparam int CIDX_W  = 5;
    localparam int COEF_W  = 48;
    localparam int VAL_W   = 48;
    localparam int ACT_W   = 7;
    localparam int IN_W    = 160;
    localparam int OUT_W   = 48;
    localparam int SPAN_W  = 2 * TIME_W + DEG_W;

    localparam int SLOT_LSB = 0;
    localparam int TA_LSB   = SLOT_LSB + SLOT_W;
    localparam int TB_LSB   = TA_LSB + TIME_W;
    localparam int DEG_LSB  = TB_LSB + TIME_W;
    localparam int CIDX_LSB = DEG_LSB + DEG_W;
    localparam int COEF_LSB = CIDX_LSB + CIDX_W;

    localparam logic [CMD_W-1:0] CMD_HDR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COEF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL = 2'd2;

    localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
    localparam logic [63:0] SATL     = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] CAP_POS  = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] CAP_NEG  = 64'h0000_8000_0000_0000;

    typedef logic [4:0] t_op;
    localparam t_op OP_NONE   = 5'd0;
    localparam t_op OP_LOAD   = 5'd1;
    localparam t_op OP_GEOM   = 5'd2;
    localparam t_op OP_ENV    = 5'd3;
    localparam t_op OP_SHAPE  = 5'd4;
    localparam t_op OP_WEIGHT = 5'd5;
    localparam t_op OP_SETWT  = 5'd6;
    localparam t_op OP_UNORM  = 5'd7;
    localparam t_op OP_C0     = 5'd8;
    localparam t_op OP_CMUL   = 5'd9;
    localparam t_op OP_CADD   = 5'd10;
    localparam t_op OP_UPOW   = 5'd11;
    localparam t_op OP_ACC    = 5'd12;
    localparam t_op OP_ACCUM  = 5'd13;
    localparam t_op OP_NEXT   = 5'd14;
    localparam t_op OP_FIN    = 5'd15;
    localparam t_op OP_EMITV  = 5'd16;
    localparam t_op OP_EMITB  = 5'd17;

    typedef struct packed {
        logic n_zero;
        logic skip;
        logic f_full;
        logic deg_zero;
        logic j_zero;
        logic last;
        logic w_zero;
        logic mul_done;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// File: hdl/bppe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bppe_ram #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                   i_wdata,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                   o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/bppe_dp.sv
// Datapath: span tables, shared multiplier and divider, accumulators, result register.
`timescale 1ns / 1ps
module bppe_dp import bppe_pkg::*; #(
    parameter int MAX_SPANS  = DEF_MAX_SPANS,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_op               i_op,
    input  logic [IN_W-1:0]   i_s_tdata,
    input  logic [CMD_W-1:0]  i_s_tuser,
    input  logic              i_cfg_valid,
    input  logic [ACT_W-1:0]  i_cfg_data,
    input  logic              i_m_tready,
    output t_sts              o_sts,
    output logic              o_m_tvalid,
    output logic [OUT_W-1:0]  o_m_tdata,
    output logic              o_m_tuser
);
    localparam int NCOEF = MAX_DEGREE + 1;
    localparam int SAW   = MAX_SPANS > 1 ? $clog2(MAX_SPANS) : 1;
    localparam int CDEP  = MAX_SPANS * NCOEF;
    localparam int CAW   = CDEP > 1 ? $clog2(CDEP) : 1;
    localparam int WW    = 34 + SAW;

    localparam logic [1:0] DM_ENV = 2'd0;
    localparam logic [1:0] DM_TM  = 2'd1;
    localparam logic [1:0] DM_FIN = 2'd2;

    function automatic logic signed [63:0] f_sadd(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (s > $signed(SATL)) return $signed(SATL);
        if (s < -$signed(SATL)) return -$signed(SATL);
        return s;
    endfunction

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // input fields
    logic [SLOT_W-1:0] f_slot;
    logic [TIME_W-1:0] f_ta, f_tb;
    logic [DEG_W-1:0]  f_deg, f_deg_c;
    logic [CIDX_W-1:0] f_ci;
    logic [COEF_W-1:0] f_coef;

    assign f_slot  = i_s_tdata[SLOT_LSB +: SLOT_W];
    assign f_ta    = i_s_tdata[TA_LSB +: TIME_W];
    assign f_tb    = i_s_tdata[TB_LSB +: TIME_W];
    assign f_deg   = i_s_tdata[DEG_LSB +: DEG_W];
    assign f_ci    = i_s_tdata[CIDX_LSB +: CIDX_W];
    assign f_coef  = i_s_tdata[COEF_LSB +: COEF_W];
    assign f_deg_c = (32'(f_deg) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : f_deg;

    // tables
    logic              s_we, c_we;
    logic [SAW-1:0]    s_waddr;
    logic [CAW-1:0]    c_waddr;
    logic [SPAN_W-1:0] s_rdata;
    logic [COEF_W-1:0] c_rdata;

    // evaluation state
    logic [ACT_W-1:0]   r_active;
    logic [TIME_W-1:0]  r_t, r_s, r_width;
    logic [ACT_W-1:0]   r_n, r_i;
    logic [CAW-1:0]     r_base, r_caddr;
    logic               r_empty;
    logic [48:0]        r_num, r_den;
    logic [DEG_W-1:0]   r_deg, r_j;
    logic [32:0]        r_f, r_wt;
    logic signed [63:0] r_u, r_upow, r_fy, r_y;
    logic [WW-1:0]      r_w;

    // multiplier
    logic [63:0]  r_ma, r_mb;
    logic         r_mneg, r_mcap, r_mbusy, r_mdone;
    logic [1:0]   r_mcnt;
    logic [127:0] r_macc;
    logic         m_go, m_neg, m_capsel;
    logic [63:0]  m_a, m_b;
    logic [31:0]  m_ah, m_bh;
    logic [63:0]  m_pp;
    logic [127:0] m_add;
    logic [63:0]  m_raw, m_capv, m_mag;
    logic signed [63:0] m_res;

    // divider
    logic [48:0]  r_dd, r_rem;
    logic [63:0]  r_bits, r_q, r_dcap;
    logic [5:0]   r_dcnt;
    logic         r_dovf, r_dbusy, r_ddone;
    logic         d_go, d_ovf;
    logic [1:0]   d_mode;
    logic [4:0]   d_ib;
    logic [63:0]  d_n, d_cap, d_res;
    logic [48:0]  d_d;
    logic [49:0]  d_tt;
    logic         d_ge;

    // result register
    logic              r_ovalid, r_obad;
    logic [OUT_W-1:0]  r_oval;

    logic signed [63:0] c_val;
    logic [48:0]        g_sum, g_t2;
    logic [TIME_W-1:0]  g_s, g_e;
    logic [63:0]        t_dist;
    logic               emit;

    assign c_val  = {{(64-COEF_W){c_rdata[COEF_W-1]}}, c_rdata};
    assign g_s    = s_rdata[0 +: TIME_W];
    assign g_e    = s_rdata[TIME_W +: TIME_W];
    assign g_sum  = 49'(g_s) + 49'(g_e);
    assign g_t2   = {r_t, 1'b0};
    assign t_dist = (r_t >= r_s) ? 64'(r_t - r_s) : 64'(r_s - r_t);
    assign emit   = (i_op == OP_EMITV) || (i_op == OP_EMITB);

    // table writes
    assign s_we    = (i_op == OP_LOAD) && (i_s_tuser == CMD_HDR) && (32'(f_slot) < MAX_SPANS);
    assign c_we    = (i_op == OP_LOAD) && (i_s_tuser == CMD_COEF) &&
                     (32'(f_slot) < MAX_SPANS) && (32'(f_ci) <= MAX_DEGREE);
    assign s_waddr = SAW'(f_slot);
    assign c_waddr = CAW'(32'(f_slot) * NCOEF + 32'(f_ci));

    bppe_ram #(.W(SPAN_W), .D(MAX_SPANS)) u_span_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata ({f_deg_c, f_tb, f_ta}),
        .i_raddr (SAW'(r_i)),
        .o_rdata (s_rdata)
    );

    bppe_ram #(.W(COEF_W), .D(CDEP)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (f_coef),
        .i_raddr (r_caddr),
        .o_rdata (c_rdata)
    );

    // multiplier result
    assign m_ah   = r_mcnt[1] ? r_ma[63:32] : r_ma[31:0];
    assign m_bh   = r_mcnt[0] ? r_mb[63:32] : r_mb[31:0];
    assign m_pp   = 64'(m_ah) * 64'(m_bh);
    assign m_raw  = r_macc[95:32];
    assign m_capv = r_mcap ? SATL : ONE_Q32;
    assign m_mag  = ((|r_macc[127:96]) || (m_raw > m_capv)) ? m_capv : m_raw;
    assign m_res  = r_mneg ? -$signed(m_mag) : $signed(m_mag);

    always_comb begin
        case (r_mcnt)
            2'd0:    m_add = {64'd0, m_pp};
            2'd3:    m_add = {m_pp, 64'd0};
            default: m_add = {32'd0, m_pp, 32'd0};
        endcase
    end

    // divider result and step
    assign d_res = r_dovf ? r_dcap : ((r_q > r_dcap) ? r_dcap : r_q);
    assign d_tt  = {r_rem, r_bits[63]};
    assign d_ge  = d_tt >= {1'b0, r_dd};

    always_comb begin
        case (d_mode)
            DM_ENV:  d_ib = 5'd1;
            DM_TM:   d_ib = 5'd30;
            default: d_ib = 5'd16;
        endcase
    end
    assign d_ovf = {16'd0, d_n} >= ({31'd0, d_d} << d_ib);

    // operand selection
    always_comb begin
        m_go     = 1'b0;
        m_a      = 64'd0;
        m_b      = 64'd0;
        m_neg    = 1'b0;
        m_capsel = 1'b1;
        d_go     = 1'b0;
        d_mode   = DM_TM;
        d_n      = t_dist;
        d_d      = 49'(r_width);
        d_cap    = SATL;
        case (i_op)
            OP_ENV: begin
                d_go   = !o_sts.skip;
                d_mode = DM_ENV;
                d_n    = 64'(r_den - r_num);
                d_d    = r_den;
                d_cap  = ONE_Q32;
            end
            OP_SHAPE: begin
                m_go     = (d_res != ONE_Q32);
                m_a      = d_res;
                m_b      = d_res;
                m_capsel = 1'b0;
                d_go     = (d_res == ONE_Q32);
            end
            OP_WEIGHT: begin
                m_go     = 1'b1;
                m_a      = m_mag;
                m_b      = 64'(ONE_Q32 * 3) - 64'({r_f, 1'b0});
                m_capsel = 1'b0;
            end
            OP_SETWT: begin
                d_go = 1'b1;
            end
            OP_CMUL: begin
                m_go  = 1'b1;
                m_a   = f_mag(c_val);
                m_b   = f_mag(r_upow);
                m_neg = c_val[63] ^ r_upow[63];
            end
            OP_CADD: begin
                m_go  = 1'b1;
                m_a   = f_mag(r_upow);
                m_b   = f_mag(r_u);
                m_neg = r_upow[63] ^ r_u[63];
            end
            OP_ACC: begin
                m_go  = 1'b1;
                m_a   = 64'(r_wt);
                m_b   = f_mag(r_fy);
                m_neg = r_fy[63];
            end
            OP_FIN: begin
                d_go   = (r_w != '0);
                d_mode = DM_FIN;
                d_n    = f_mag(r_y);
                d_d    = 49'(r_w);
                d_cap  = r_y[63] ? CAP_NEG : CAP_POS;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_mbusy  <= 1'b0;
            r_mdone  <= 1'b0;
            r_mcnt   <= 2'd0;
            r_dbusy  <= 1'b0;
            r_ddone  <= 1'b0;
            r_dcnt   <= 6'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
            r_mdone <= 1'b0;
            if (m_go) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= 2'd0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 2'd1;
                if (r_mcnt == 2'd3) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
            r_ddone <= 1'b0;
            if (d_go) begin
                r_dbusy <= !d_ovf;
                r_ddone <= d_ovf;
                r_dcnt  <= 6'(d_ib) + 6'd32;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt - 6'd1;
                if (r_dcnt == 6'd1) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (m_go) begin
            r_ma   <= m_a;
            r_mb   <= m_b;
            r_mneg <= m_neg;
            r_mcap <= m_capsel;
            r_macc <= '0;
        end else if (r_mbusy) begin
            r_macc <= r_macc + m_add;
        end

        if (d_go) begin
            r_dd   <= d_d;
            r_rem  <= 49'(d_n >> d_ib);
            r_bits <= d_n << (7'd64 - 7'(d_ib));
            r_q    <= '0;
            r_dcap <= d_cap;
            r_dovf <= d_ovf;
        end else if (r_dbusy) begin
            r_rem  <= d_ge ? 49'(d_tt - {1'b0, r_dd}) : 49'(d_tt);
            r_bits <= {r_bits[62:0], 1'b0};
            r_q    <= {r_q[62:0], d_ge};
        end

        case (i_op)
            OP_LOAD: begin
                r_t    <= f_ta;
                r_n    <= (32'(r_active) > MAX_SPANS) ? ACT_W'(MAX_SPANS) : r_active;
                r_i    <= '0;
                r_base <= '0;
                r_y    <= '0;
                r_w    <= '0;
            end
            OP_GEOM: begin
                r_s     <= g_s;
                r_empty <= g_e <= g_s;
                r_width <= g_e - g_s;
                r_num   <= (g_t2 > g_sum) ? g_t2 - g_sum : g_sum - g_t2;
                r_den   <= 49'(g_e - g_s) + 49'(ONE_Q32 >> 15);
                r_deg   <= s_rdata[2*TIME_W +: DEG_W];
            end
            OP_SHAPE: begin
                r_f <= 33'(d_res);
                if (d_res == ONE_Q32) begin
                    r_wt <= 33'(ONE_Q32);
                end
            end
            OP_SETWT: begin
                r_wt <= 33'(m_mag);
            end
            OP_UNORM: begin
                r_u     <= (r_t >= r_s) ? $signed(d_res) : -$signed(d_res);
                r_upow  <= (r_t >= r_s) ? $signed(d_res) : -$signed(d_res);
                r_caddr <= r_base + CAW'(r_deg);
            end
            OP_C0: begin
                r_fy    <= c_val;
                r_j     <= r_deg - DEG_W'(1);
                r_caddr <= r_caddr - CAW'(1);
            end
            OP_CADD: begin
                r_fy <= f_sadd(r_fy, m_res);
            end
            OP_UPOW: begin
                r_upow <= m_res;
                if (r_j != '0) begin
                    r_j     <= r_j - DEG_W'(1);
                    r_caddr <= r_caddr - CAW'(1);
                end
            end
            OP_ACCUM: begin
                r_y    <= f_sadd(r_y, m_res);
                r_w    <= r_w + WW'(r_wt);
                r_i    <= r_i + ACT_W'(1);
                r_base <= r_base + CAW'(NCOEF);
            end
            OP_NEXT: begin
                r_i    <= r_i + ACT_W'(1);
                r_base <= r_base + CAW'(NCOEF);
            end
            OP_EMITV: begin
                r_oval <= r_y[63] ? OUT_W'(-d_res) : OUT_W'(d_res);
                r_obad <= 1'b0;
            end
            OP_EMITB: begin
                r_oval <= '0;
                r_obad <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.n_zero   = (r_n == '0);
    assign o_sts.skip     = r_empty || (r_num > r_den);
    assign o_sts.f_full   = (d_res == ONE_Q32);
    assign o_sts.deg_zero = (r_deg == '0);
    assign o_sts.j_zero   = (r_j == '0);
    assign o_sts.last     = ({1'b0, r_i} + 8'd1) == {1'b0, r_n};
    assign o_sts.w_zero   = (r_w == '0);
    assign o_sts.mul_done = r_mdone;
    assign o_sts.div_done = r_ddone;
    assign o_sts.out_free = !r_ovalid || i_m_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_oval;
    assign o_m_tuser  = r_obad;
endmodule

// File: hdl/bppe_ctrl.sv
// Sequencer that walks each evaluation over the active spans and their coefficients.
`timescale 1ns / 1ps
module bppe_ctrl import bppe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic [CMD_W-1:0] i_cmd,
    input  t_sts             i_sts,
    output logic             o_ready,
    output t_op              o_op
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_START = 5'd1;
    localparam logic [4:0] S_RD    = 5'd2;
    localparam logic [4:0] S_GEOM  = 5'd3;
    localparam logic [4:0] S_ENV   = 5'd4;
    localparam logic [4:0] S_DIV1  = 5'd5;
    localparam logic [4:0] S_M1    = 5'd6;
    localparam logic [4:0] S_M2    = 5'd7;
    localparam logic [4:0] S_DIV2  = 5'd8;
    localparam logic [4:0] S_CRD0  = 5'd9;
    localparam logic [4:0] S_C0    = 5'd10;
    localparam logic [4:0] S_CRD   = 5'd11;
    localparam logic [4:0] S_CMUL  = 5'd12;
    localparam logic [4:0] S_CM1   = 5'd13;
    localparam logic [4:0] S_CM2   = 5'd14;
    localparam logic [4:0] S_ACC   = 5'd15;
    localparam logic [4:0] S_ACCW  = 5'd16;
    localparam logic [4:0] S_SKIP  = 5'd17;
    localparam logic [4:0] S_FIN   = 5'd18;
    localparam logic [4:0] S_FDIV  = 5'd19;
    localparam logic [4:0] S_EMITV = 5'd20;
    localparam logic [4:0] S_EMITB = 5'd21;

    logic [4:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_op = OP_LOAD;
                    if (i_cmd == CMD_EVAL) n_state = S_START;
                end
            end
            S_START: n_state = i_sts.n_zero ? S_EMITB : S_RD;
            S_RD:    n_state = S_GEOM;
            S_GEOM: begin
                o_op    = OP_GEOM;
                n_state = S_ENV;
            end
            S_ENV: begin
                o_op    = OP_ENV;
                n_state = i_sts.skip ? S_SKIP : S_DIV1;
            end
            S_DIV1: begin
                if (i_sts.div_done) begin
                    o_op    = OP_SHAPE;
                    n_state = i_sts.f_full ? S_DIV2 : S_M1;
                end
            end
            S_M1: begin
                if (i_sts.mul_done) begin
                    o_op    = OP_WEIGHT;
                    n_state = S_M2;
                end
            end
            S_M2: begin
                if (i_sts.mul_done) begin
                    o_op    = OP_SETWT;
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                if (i_sts.div_done) begin
                    o_op    = OP_UNORM;
                    n_state = S_CRD0;
                end
            end
            S_CRD0: n_state = S_C0;
            S_C0: begin
                o_op    = OP_C0;
                n_state = i_sts.deg_zero ? S_ACC : S_CRD;
            end
            S_CRD: n_state = S_CMUL;
            S_CMUL: begin
                o_op    = OP_CMUL;
                n_state = S_CM1;
            end
            S_CM1: begin
                if (i_sts.mul_done) begin
                    o_op    = OP_CADD;
                    n_state = S_CM2;
                end
            end
            S_CM2: begin
                if (i_sts.mul_done) begin
                    o_op    = OP_UPOW;
                    n_state = i_sts.j_zero ? S_ACC : S_CRD;
                end
            end
            S_ACC: begin
                o_op    = OP_ACC;
                n_state = S_ACCW;
            end
            S_ACCW: begin
                if (i_sts.mul_done) begin
                    o_op    = OP_ACCUM;
                    n_state = i_sts.last ? S_FIN : S_RD;
                end
            end
            S_SKIP: begin
                o_op    = OP_NEXT;
                n_state = i_sts.last ? S_FIN : S_RD;
            end
            S_FIN: begin
                o_op    = OP_FIN;
                n_state = i_sts.w_zero ? S_EMITB : S_FDIV;
            end
            S_FDIV: begin
                if (i_sts.div_done) n_state = S_EMITV;
            end
            S_EMITV: begin
                if (i_sts.out_free) begin
                    o_op    = OP_EMITV;
                    n_state = S_IDLE;
                end
            end
            S_EMITB: begin
                if (i_sts.out_free) begin
                    o_op    = OP_EMITB;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
endmodule

// File: hdl/blended_piecewise_poly_eval_unit.sv
// Top level: blended piecewise polynomial evaluator, controller plus datapath.
// Header and coefficient writes may follow back to back.
// An evaluation's length grows with the number of spans and, for each used span, with its
// degree; a skipped span costs less than a used one. The shared 1-bit/cycle divider and
// the shared 32x32 multiplier set these costs. One evaluation is in flight at a time.
// Synchronous active-low reset clears active_spans and control; tables stay unwritten.
`timescale 1ns / 1ps
module blended_piecewise_poly_eval_unit import bppe_pkg::*; #(
    parameter int MAX_SPANS  = DEF_MAX_SPANS,
    parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // slot, time_a, time_b, poly_degree, coef_index, coef_value
    input  logic [IN_W-1:0]  i_s_tdata,
    // cmd
    input  logic [CMD_W-1:0] i_s_tuser,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [ACT_W-1:0] i_cfg_data,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // value
    output logic [OUT_W-1:0] o_m_tdata,
    // bad
    output logic             o_m_tuser
);
    t_op  op;
    t_sts sts;

    bppe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_cmd      (i_s_tuser),
        .i_sts      (sts),
        .o_ready    (o_s_tready),
        .o_op       (op)
    );

    bppe_dp #(.MAX_SPANS(MAX_SPANS), .MAX_DEGREE(MAX_DEGREE)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    assign o_cfg_ready = 1'b1;
endmodule

// File: hdl/bppe_chk.sv
// Port-level checks of the evaluator, bound to the top level.
`timescale 1ns / 1ps
module bppe_chk import bppe_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic [CMD_W-1:0] i_s_tuser,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [OUT_W-1:0] o_m_tdata,
    input logic             o_m_tuser
);
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("bad result with nonzero value");

    a_result_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result appeared without an evaluation in progress");

    a_write_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser != CMD_EVAL) |=> o_s_tready)
        else $error("write transfer blocked the input");
endmodule

bind blended_piecewise_poly_eval_unit bppe_chk u_bppe_chk (.*);
